// ===== src/tmhq_pkg.sv =====
// Shared types and codes for the ternary min-heap priority queue.
// No dependencies; imported by the queue top level, its checker and the bench.
`timescale 1ns / 1ps

package tmhq_pkg;

  // Fixed field widths of the stream payloads
  localparam int PRIO_BITS   = 32;
  localparam int IO_TAG_BITS = 16;
  localparam int COUNT_BITS  = 7;

  // Action codes carried in the input tuser
  localparam logic ACT_INSERT = 1'b0;
  localparam logic ACT_REMOVE = 1'b1;

  // Result status codes carried in the output tuser
  typedef enum logic [1:0] {
    ST_INSERTED = 2'd0,
    ST_REMOVED  = 2'd1,
    ST_EMPTY    = 2'd2,
    ST_FULL     = 2'd3
  } status_t;

  // Sequencer states
  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_RM_ROOT,
    S_RM_LAST,
    S_UP_LEVEL,
    S_UP_CMP,
    S_DN_LEVEL,
    S_DN_SCAN,
    S_DN_DEC,
    S_FINISH
  } state_t;

endpackage

// ===== src/ternary_min_heap_queue.sv =====
// Ternary min-heap priority queue: heap memory, sift sequencer, one shared comparator.
// Depends on tmhq_pkg (codes, state type, field widths).
//
//   channel   dir  signals                        transfer carries
//   s_*       in   s_tvalid s_tready s_tdata s_tuser   one insert or remove request
//   m_*       out  m_tvalid m_tready m_tdata m_tuser   one result per request
//
// An insert climbs one level per parent read and compare, moving the parent down into
// the hole, until it settles; a remove reads the root, moves the last entry to the root
// and sinks it one level per scan of its children, read one at a time. A full insert, an
// empty remove or the removal of the last entry needs no sift. The single read port of
// the heap memory and the one comparator set this order of steps.
// Reset clears the sequencer, the entry count and the output valid; the heap
// memory is not cleared, only slots below the count are ever read.
// A new request is taken while a finished result still waits on m_*; the last
// cycle of a request holds until the output register is free.
`timescale 1ns / 1ps

module ternary_min_heap_queue #(
  parameter int CAPACITY = 64,
  parameter int TAG_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [47:0] s_tdata,   // [31:0] priority_req, [47:32] tag
  input  logic [0:0]  s_tuser,   // [0] action
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [55:0] m_tdata,   // [31:0] removed_prio, [47:32] tag_out, [54:48] count
  output logic [1:0]  m_tuser    // [1:0] status
);

  import tmhq_pkg::*;

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;  // slot address
  localparam int CW = $clog2(CAPACITY + 1);                    // entry count
  localparam int XW = AW + 2;                                  // child index math
  localparam int EW = PRIO_BITS + TAG_BITS;                    // {tag, priority}
  // floor(x/3) = (x * RECIP) >> RS for every x below 2**AW
  localparam int RS = AW + 1;
  localparam int unsigned RECIP = ((1 << RS) + 2) / 3;
  localparam int PW = AW + RS;

  state_t state, state_next;

  logic                act;
  logic [EW-1:0]       cur;
  logic [EW-1:0]       best;
  logic [AW-1:0]       best_addr;
  logic [AW-1:0]       pos;
  logic [AW-1:0]       par_addr;
  logic [AW-1:0]       kaddr;
  logic [1:0]          kidx;
  logic [CW-1:0]       count;
  status_t             res_status;
  logic [PRIO_BITS-1:0]   res_prio;
  logic [IO_TAG_BITS-1:0] res_tag;

  // heap memory and its ports
  logic [EW-1:0] mem [CAPACITY];
  logic [EW-1:0] rdata;
  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [EW-1:0] wr_data;

  // shared comparator
  logic [PRIO_BITS-1:0] cmp_a;
  logic [PRIO_BITS-1:0] cmp_b;
  logic                 cmp_less;

  // index arithmetic
  logic [PW-1:0] par_prod;
  logic [AW-1:0] parent;
  logic [XW-1:0] first_x;
  logic          first_ok;
  logic [XW-1:0] next_k;
  logic          next_ok;
  logic          out_free;

  assign s_tready = (state == S_IDLE);
  assign out_free = !m_tvalid || m_tready;

  // parent = (pos - 1) / 3 by reciprocal multiply
  assign par_prod = PW'(pos - AW'(1)) * PW'(RECIP);
  assign parent   = par_prod[PW-1:RS];

  // first child = 3 * pos + 1, and the next sibling during the scan
  assign first_x  = (XW'(pos) << 1) + XW'(pos) + XW'(1);
  assign first_ok = first_x < XW'(count);
  assign next_k   = XW'(kaddr) + XW'(1);
  assign next_ok  = (kidx != 2'd2) && (next_k < XW'(count));

  assign cmp_less = $signed(cmp_a) < $signed(cmp_b);

  // heap memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata <= mem[rd_addr];
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (s_tvalid) state_next = S_DISPATCH;
      end
      S_DISPATCH: begin
        if (act == ACT_INSERT) begin
          state_next = (count >= CW'(CAPACITY)) ? S_FINISH : S_UP_LEVEL;
        end else begin
          state_next = (count == '0) ? S_FINISH : S_RM_ROOT;
        end
      end
      S_RM_ROOT: begin
        state_next = (count == CW'(1)) ? S_FINISH : S_RM_LAST;
      end
      S_RM_LAST:  state_next = S_DN_LEVEL;
      S_UP_LEVEL: state_next = (pos == '0) ? S_FINISH : S_UP_CMP;
      S_UP_CMP:   state_next = cmp_less ? S_UP_LEVEL : S_FINISH;
      S_DN_LEVEL: state_next = first_ok ? S_DN_SCAN : S_FINISH;
      S_DN_SCAN:  state_next = next_ok ? S_DN_SCAN : S_DN_DEC;
      S_DN_DEC:   state_next = cmp_less ? S_DN_LEVEL : S_FINISH;
      S_FINISH: begin
        if (out_free) state_next = S_IDLE;
      end
      default:    state_next = S_IDLE;
    endcase
  end

  // memory controls and comparator operands
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = '0;
    wr_en   = 1'b0;
    wr_addr = pos;
    wr_data = cur;
    cmp_a   = cur[PRIO_BITS-1:0];
    cmp_b   = rdata[PRIO_BITS-1:0];
    case (state)
      S_DISPATCH: begin
        // fetch the root for a remove
        if (act == ACT_REMOVE && count != '0) rd_en = 1'b1;
      end
      S_RM_ROOT: begin
        // fetch the last entry, it moves to the root
        if (count != CW'(1)) begin
          rd_en   = 1'b1;
          rd_addr = AW'(count - CW'(1));
        end
      end
      S_UP_LEVEL: begin
        if (pos != '0) begin
          rd_en   = 1'b1;
          rd_addr = parent;
        end else begin
          wr_en = 1'b1;
        end
      end
      S_UP_CMP: begin
        // parent moves down into the hole, or the new entry settles here
        wr_en   = 1'b1;
        wr_data = cmp_less ? rdata : cur;
      end
      S_DN_LEVEL: begin
        if (first_ok) begin
          rd_en   = 1'b1;
          rd_addr = first_x[AW-1:0];
        end else begin
          wr_en = 1'b1;
        end
      end
      S_DN_SCAN: begin
        cmp_a = rdata[PRIO_BITS-1:0];
        cmp_b = best[PRIO_BITS-1:0];
        if (next_ok) begin
          rd_en   = 1'b1;
          rd_addr = next_k[AW-1:0];
        end
      end
      S_DN_DEC: begin
        // smallest child moves up into the hole, or the moved entry settles here
        cmp_a   = best[PRIO_BITS-1:0];
        cmp_b   = cur[PRIO_BITS-1:0];
        wr_en   = 1'b1;
        wr_data = cmp_less ? best : cur;
      end
      default: begin
      end
    endcase
  end

  // sequencer state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // control registers with reset: entry count and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= '0;
      m_tvalid <= 1'b0;
    end else begin
      // result valid: set as a finished result loads, cleared once taken
      if (state == S_FINISH && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        S_DISPATCH: begin
          if (act == ACT_INSERT && count < CW'(CAPACITY)) count <= count + CW'(1);
        end
        S_RM_ROOT: count <= count - CW'(1);
        default: begin
        end
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          act      <= s_tuser[0];
          cur      <= {TAG_BITS'(s_tdata[47:32]), s_tdata[31:0]};
          res_prio <= '0;
          res_tag  <= '0;
        end
      end
      S_DISPATCH: begin
        if (act == ACT_INSERT) begin
          if (count >= CW'(CAPACITY)) begin
            res_status <= ST_FULL;
          end else begin
            res_status <= ST_INSERTED;
            pos        <= AW'(count);
          end
        end else begin
          res_status <= (count == '0) ? ST_EMPTY : ST_REMOVED;
        end
      end
      S_RM_ROOT: begin
        res_prio <= rdata[PRIO_BITS-1:0];
        res_tag  <= IO_TAG_BITS'(rdata[EW-1:PRIO_BITS]);
      end
      S_RM_LAST: begin
        cur <= rdata;
        pos <= '0;
      end
      S_UP_LEVEL: par_addr <= parent;
      S_UP_CMP: begin
        if (cmp_less) pos <= par_addr;
      end
      S_DN_LEVEL: begin
        kaddr <= first_x[AW-1:0];
        kidx  <= 2'd0;
      end
      S_DN_SCAN: begin
        // left child wins ties
        if (kidx == 2'd0 || cmp_less) begin
          best      <= rdata;
          best_addr <= kaddr;
        end
        if (next_ok) begin
          kaddr <= next_k[AW-1:0];
          kidx  <= kidx + 2'd1;
        end
      end
      S_DN_DEC: begin
        if (cmp_less) pos <= best_addr;
      end
      S_FINISH: begin
        if (out_free) begin
          m_tdata <= {1'b0, COUNT_BITS'(count), res_tag, res_prio};
          m_tuser <= res_status;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

// ===== src/tmhq_checker.sv =====
// Port-level checks for the ternary min-heap priority queue, bound to its top level.
// Depends on tmhq_pkg (status codes) and the ternary_min_heap_queue ports.
`timescale 1ns / 1ps

module tmhq_checker #(
  parameter int CAPACITY = 64
) (
  input logic        clk,
  input logic        rst,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [55:0] m_tdata,   // [31:0] removed_prio, [47:32] tag_out, [54:48] count
  input logic [1:0]  m_tuser    // [1:0] status
);

  import tmhq_pkg::*;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result changed while stalled");

  // only a remove returns an entry
  a_zero_fields: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser == ST_INSERTED || m_tuser == ST_EMPTY || m_tuser == ST_FULL)
    |-> m_tdata[47:0] == 48'd0)
    else $error("nonzero entry on a result that removed nothing");

  // empty report means no entries held
  a_empty_count: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser == ST_EMPTY |-> m_tdata[54:48] == 7'd0)
    else $error("empty status with nonzero count");

  // full report means the heap is at capacity
  a_full_count: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser == ST_FULL |-> m_tdata[54:48] == COUNT_BITS'(CAPACITY))
    else $error("full status below capacity");

  // reset leaves the block ready with no result pending
  a_reset_idle: assert property (@(posedge clk)
    rst |=> s_tready && !m_tvalid)
    else $error("not idle after reset");

endmodule

bind ternary_min_heap_queue tmhq_checker #(.CAPACITY(CAPACITY)) u_tmhq_checker (.*);

// ===== tb/ternary_min_heap_queue_tb.sv =====
// Self-checking bench for the ternary min-heap priority queue: directed and random
// insert/remove traffic with an in-bench heap predictor. Depends on tmhq_pkg and the RTL.
`timescale 1ns / 1ps

module ternary_min_heap_queue_tb;
  import tmhq_pkg::*;

  localparam int DEPTH      = 64;
  localparam int STALL_MAX  = 4000;  // cycles with no transfer before giving up
  localparam int SETTLE     = 40;

  typedef struct packed {
    logic              act;
    logic signed [31:0] prio;
    logic [15:0]       tag;
  } req_t;

  typedef struct packed {
    logic signed [31:0] prio;
    logic [15:0]       tag;
  } slot_t;

  typedef struct packed {
    status_t           status;
    logic signed [31:0] prio;
    logic [15:0]       tag;
    logic [6:0]        count;
  } result_t;

  logic        clk;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [47:0] s_tdata = '0;   // [31:0] priority_req, [47:32] tag
  logic [0:0]  s_tuser = '0;   // [0] action
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [55:0] m_tdata;        // [31:0] removed_prio, [47:32] tag_out, [54:48] count
  logic [1:0]  m_tuser;        // [1:0] status

  ternary_min_heap_queue #(
    .CAPACITY(DEPTH),
    .TAG_BITS(16)
  ) dut (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .s_tuser (s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tuser (m_tuser)
  );

  // Stimulus and scoreboard state
  req_t    req_queue[$];
  result_t due_results[$];
  int      reqs_queued   = 0;
  int      reqs_taken    = 0;
  int      errors        = 0;
  int      send_idle_pct = 0;
  int      recv_stall_pct = 0;
  logic    s_accepted    = 1'b0;
  int      n_inserted = 0, n_removed = 0, n_empty = 0, n_full = 0, n_checked = 0;

  // Shadow heap
  slot_t   heap_slots[DEPTH];
  int      heap_count = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Predictor: apply one request to the shadow heap, return the queue's answer
  function automatic result_t queue_step(input logic act, input logic signed [31:0] prio,
                                         input logic [15:0] tag);
    result_t r;
    slot_t   tmp;
    int      pos, up, first, best, c;
    r.status = ST_INSERTED;
    r.prio   = '0;
    r.tag    = '0;
    if (act == ACT_INSERT) begin
      if (heap_count >= DEPTH) begin
        r.status = ST_FULL;
      end else begin
        pos = heap_count;
        heap_slots[pos].prio = prio;
        heap_slots[pos].tag  = tag;
        heap_count++;
        // climb while the parent is strictly greater
        while (pos > 0) begin
          up = (pos - 1) / 3;
          if (!(heap_slots[pos].prio < heap_slots[up].prio)) break;
          tmp = heap_slots[pos];
          heap_slots[pos] = heap_slots[up];
          heap_slots[up] = tmp;
          pos = up;
        end
      end
    end else begin
      if (heap_count == 0) begin
        r.status = ST_EMPTY;
      end else begin
        r.status = ST_REMOVED;
        r.prio   = heap_slots[0].prio;
        r.tag    = heap_slots[0].tag;
        heap_count--;
        heap_slots[0] = heap_slots[heap_count];
        // sink toward the smallest child, leftmost wins ties
        pos = 0;
        while (pos < heap_count) begin
          first = 3 * pos + 1;
          if (first >= heap_count) break;
          best = first;
          for (int k = 1; k < 3; k++) begin
            c = first + k;
            if (c < heap_count && heap_slots[c].prio < heap_slots[best].prio) best = c;
          end
          if (!(heap_slots[best].prio < heap_slots[pos].prio)) break;
          tmp = heap_slots[pos];
          heap_slots[pos] = heap_slots[best];
          heap_slots[best] = tmp;
          pos = best;
        end
      end
    end
    r.count = 7'(heap_count);
    return r;
  endfunction

  function automatic void add_req(input logic act, input logic [31:0] prio,
                                  input logic [15:0] tag);
    req_t q;
    q.act  = act;
    q.prio = prio;
    q.tag  = tag;
    req_queue.push_back(q);
    reqs_queued++;
  endfunction

  // Mix of full-range, clustered (tie-heavy) and extreme priorities
  function automatic logic [31:0] rand_prio();
    int v;
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 3))
          0: return 32'h8000_0000;
          1: return 32'h7fff_ffff;
          2: return 32'h0000_0000;
          default: return 32'hffff_ffff;
        endcase
      end
      1, 2, 3: begin
        v = $urandom_range(0, 8);
        return v - 4;
      end
      default: return $urandom;
    endcase
  endfunction

  // Random traffic: fill bursts, drain bursts and biased mixed stretches
  task automatic gen_random(input int n);
    int made, mode, len, bias;
    made = 0;
    while (made < n) begin
      mode = $urandom_range(0, 9);
      len  = (mode <= 1) ? $urandom_range(66, 72) : $urandom_range(8, 40);
      bias = (mode == 0) ? 100 : (mode == 1) ? 0 : (mode < 5) ? 75 : (mode < 8) ? 50 : 25;
      repeat (len) begin
        if ($urandom_range(0, 99) < bias)
          add_req(ACT_INSERT, rand_prio(), 16'($urandom_range(0, 65535)));
        else
          add_req(ACT_REMOVE, $urandom, 16'($urandom));
      end
      made += len;
    end
  endtask

  // Hold the sender until every request is taken and answered
  task automatic drain_wait();
    while (reqs_taken != reqs_queued || due_results.size() != 0) @(posedge clk);
  endtask

  // Driver: inputs change on the falling edge
  always @(negedge clk) begin : drive
    req_t nxt;
    if (rst) begin
      s_tvalid <= 1'b0;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
      if (!s_tvalid || s_accepted) begin
        if (req_queue.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          nxt = req_queue.pop_front();
          s_tvalid <= 1'b1;
          s_tdata  <= {nxt.tag, nxt.prio};
          s_tuser  <= nxt.act;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor: check results, then predict for a newly taken request
  always @(posedge clk) begin : observe
    result_t got, want;
    if (rst) begin
      s_accepted <= 1'b0;
    end else begin
      s_accepted <= s_tvalid && s_tready;
      if (m_tvalid && m_tready) begin
        got.status = status_t'(m_tuser);
        got.prio   = m_tdata[31:0];
        got.tag    = m_tdata[47:32];
        got.count  = m_tdata[54:48];
        if (due_results.size() == 0) begin
          errors++;
          $display("%0t: unexpected result status=%s prio=%0d tag=%h count=%0d",
                   $time, got.status.name(), got.prio, got.tag, got.count);
        end else begin
          want = due_results.pop_front();
          n_checked++;
          if (got !== want) begin
            errors++;
            // fields: status priority/tag/count
            $display("%0t: mismatch exp %s %0d/%h/%0d, got %s %0d/%h/%0d",
                     $time, want.status.name(), want.prio, want.tag, want.count,
                     got.status.name(), got.prio, got.tag, got.count);
          end
        end
      end
      if (s_tvalid && s_tready) begin
        want = queue_step(s_tuser[0], s_tdata[31:0], s_tdata[47:32]);
        due_results.push_back(want);
        reqs_taken++;
        case (want.status)
          ST_INSERTED: n_inserted++;
          ST_REMOVED:  n_removed++;
          ST_EMPTY:    n_empty++;
          default:     n_full++;
        endcase
      end
    end
  end

  // Watchdog: too long without any transfer on either side
  always @(posedge clk) begin : watchdog
    int quiet;
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet = 0;
    end else begin
      quiet++;
      if (quiet >= STALL_MAX) begin
        $display("%0t: no transfer for %0d cycles", $time, quiet);
        $display("FAIL");
        $finish;
      end
    end
  end

  initial begin
    send_idle_pct  = 26;
    recv_stall_pct = 62;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed: empty remove, priority and tag extremes, ties, drain past empty
    add_req(ACT_REMOVE, 32'h0, 16'h0);
    add_req(ACT_INSERT, 32'h7fff_ffff, 16'h0000);
    add_req(ACT_INSERT, 32'h8000_0000, 16'hffff);
    add_req(ACT_INSERT, 32'h0000_0000, 16'h0001);
    add_req(ACT_INSERT, 32'hffff_ffff, 16'h0002);
    add_req(ACT_INSERT, 32'd5, 16'h0003);
    add_req(ACT_INSERT, 32'd5, 16'h0004);
    add_req(ACT_INSERT, 32'd5, 16'h0005);
    add_req(ACT_INSERT, 32'd5, 16'h0006);
    add_req(ACT_INSERT, 32'h8000_0000, 16'h0007);
    repeat (10) add_req(ACT_REMOVE, 32'hffff_ffff, 16'hffff);

    // Phase 1: sender idles a little, receiver stalls a lot
    gen_random(560);
    drain_wait();

    // Phase 2: the other way round
    send_idle_pct  = 62;
    recv_stall_pct = 26;
    gen_random(560);
    drain_wait();

    // Phase 3: back to back, no idling
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    gen_random(560);
    drain_wait();
    repeat (SETTLE) @(posedge clk);

    $display("Checked %0d results over %0d requests under three idle/stall mixes.",
             n_checked, reqs_taken);
    $display("Inserted %0d, removed %0d, empty removes %0d, dropped on full %0d.",
             n_inserted, n_removed, n_empty, n_full);
    if (errors == 0 && due_results.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
